>>> hw/rtl/box_blur_window_mean_macros.svh
// Assertion macros used by the box blur back end (bbwm_back).
`ifndef BOX_BLUR_WINDOW_MEAN_MACROS_SVH
`define BOX_BLUR_WINDOW_MEAN_MACROS_SVH
`ifndef SYNTHESIS
`define BBWM_ASSERT_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("bbwm assertion failed");
`define BBWM_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("bbwm assertion failed");
`else
`define BBWM_ASSERT_IMPL(lbl, clk, rstn, a, b)
`define BBWM_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

>>> hw/rtl/bbwm_pkg.sv
`timescale 1ns / 1ps
package bbwm_pkg;
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 13;
    localparam int QUO_W      = 8;
    localparam int QSTEP_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RESET = 12'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FLUSH,
        BK_LOAD,
        BK_DIV,
        BK_OUT
    } t_bk_state;
endpackage

>>> hw/rtl/bbwm_line_mem.sv
`timescale 1ns / 1ps
module bbwm_line_mem
    import bbwm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW    = 5
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(WINDOW)-1:0]  i_wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_col,
    input  logic [3*PIX_W-1:0]         i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(WINDOW)-1:0]  i_rd_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_col,
    output logic [3*PIX_W-1:0]         o_rd_data
);
    logic [3*PIX_W-1:0] r_mem [WINDOW][MAX_WIDTH];
    logic [3*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_slot][i_wr_col] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_slot][i_rd_col];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> hw/rtl/bbwm_run_fifo.sv
`timescale 1ns / 1ps
module bbwm_run_fifo
    import bbwm_pkg::*;
#(
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
endmodule

>>> hw/rtl/bbwm_front.sv
`timescale 1ns / 1ps
module bbwm_front
    import bbwm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW    = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_op,
    input  logic [3*PIX_W-1:0]             i_pix,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_w,
    input  logic [CFG_W-1:0]               i_h,
    input  logic                           i_pos_clear,
    output logic                           o_we,
    output logic [$clog2(WINDOW)-1:0]      o_wr_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_wr_col,
    output logic [3*PIX_W-1:0]             o_wr_data,
    output logic                           o_run_push,
    output logic [ROW_W-1:0]               o_run_r,
    output logic [$clog2(WINDOW)-1:0]      o_run_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_run_lo,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_run_hi,
    output logic                           o_run_fend
);
    localparam int HALF = WINDOW / 2;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int SLW  = $clog2(WINDOW);

    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic [SLW-1:0]   r_slot;

    logic             last_col;
    logic             col_ge;
    logic             row_ge;
    logic [ROW_W-1:0] out_r;

    assign last_col = (WW'(r_col) == i_w - WW'(1));
    assign col_ge   = (r_col >= CW'(HALF));
    assign row_ge   = (r_row >= ROW_W'(HALF));
    assign out_r    = r_row - ROW_W'(HALF);

    assign o_we      = i_accept && (r_row < ROW_W'(i_h));
    assign o_wr_slot = r_slot;
    assign o_wr_col  = r_col;
    assign o_wr_data = (i_op == OP_DRAIN) ? '0 : i_pix;

    assign o_run_push = i_accept && row_ge && (last_col || col_ge);
    assign o_run_r    = out_r;
    assign o_run_slot = r_slot;
    assign o_run_lo   = col_ge ? r_col - CW'(HALF) : '0;
    assign o_run_hi   = last_col ? CW'(i_w - WW'(1)) : r_col - CW'(HALF);
    assign o_run_fend = last_col && (out_r == ROW_W'(i_h) - ROW_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_pos_clear) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_accept) begin
            if (last_col) begin
                r_col <= '0;
                if (r_row + ROW_W'(1) >= ROW_W'(i_h) + ROW_W'(HALF)) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_slot <= (r_slot == SLW'(WINDOW - 1)) ? '0 : r_slot + SLW'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end
endmodule

>>> hw/rtl/bbwm_back.sv
`timescale 1ns / 1ps
`include "box_blur_window_mean_macros.svh"
module bbwm_back
    import bbwm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW    = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_w,
    input  logic [CFG_W-1:0]               i_h,
    input  logic                           i_run_valid,
    input  logic [ROW_W-1:0]               i_run_r,
    input  logic [$clog2(WINDOW)-1:0]      i_run_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_run_lo,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_run_hi,
    input  logic                           i_run_fend,
    output logic                           o_run_take,
    output logic                           o_busy,
    output logic                           o_rd_en,
    output logic [$clog2(WINDOW)-1:0]      o_rd_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_rd_col,
    input  logic [3*PIX_W-1:0]             i_rd_data,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [PIX_W-1:0]               o_avg_blue,
    output logic [PIX_W-1:0]               o_avg_green,
    output logic [PIX_W-1:0]               o_avg_red,
    output logic                           o_run_end,
    output logic                           o_frame_end
);
    localparam int HALF = WINDOW / 2;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int SLW  = $clog2(WINDOW);
    localparam int DW   = $clog2(WINDOW);
    localparam int SW   = PIX_W + $clog2(WINDOW * WINDOW);
    localparam int NW   = $clog2(WINDOW * WINDOW + 1);
    localparam int XW   = SW + NW;

    t_bk_state r_state, n_state;

    logic [ROW_W-1:0] r_r;
    logic [CW-1:0]    r_c;
    logic [CW-1:0]    r_hi;
    logic             r_fend;
    logic [SLW-1:0]   r_slot0;
    logic [SLW-1:0]   r_slot;
    logic [DW-1:0]    r_dy;
    logic [DW-1:0]    r_dx;
    logic             r_pv;
    logic [SW-1:0]    r_sb, r_sg, r_sr;
    logic [NW-1:0]    r_cnt;
    logic [XW-1:0]    r_rb, r_rg, r_rr;
    logic [XW-1:0]    r_dvs;
    logic [QUO_W-1:0] r_qb, r_qg, r_qr;
    logic [QSTEP_W-1:0] r_step;
    logic             r_ov;

    logic [ROW_W:0]   ry;
    logic [CW:0]      cx;
    logic             tap_ok;
    logic             scan_last;
    logic             run_last;
    logic             out_wr;
    logic [SLW-1:0]   take_slot;

    assign ry        = {1'b0, r_r} + (ROW_W + 1)'(r_dy);
    assign cx        = {1'b0, r_c} + (CW + 1)'(r_dx);
    assign tap_ok    = (ry >= (ROW_W + 1)'(HALF))
                    && (ry < (ROW_W + 1)'(i_h) + (ROW_W + 1)'(HALF))
                    && (cx >= (CW + 1)'(HALF))
                    && (cx < (CW + 1)'(i_w) + (CW + 1)'(HALF));
    assign scan_last = (r_dy == DW'(WINDOW - 1)) && (r_dx == DW'(WINDOW - 1));
    assign run_last  = (r_c == r_hi);
    assign take_slot = (i_run_slot == SLW'(WINDOW - 1)) ? '0 : i_run_slot + SLW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (i_run_valid) n_state = BK_SCAN;
            BK_SCAN:  if (scan_last) n_state = BK_FLUSH;
            BK_FLUSH: n_state = BK_LOAD;
            BK_LOAD:  n_state = BK_DIV;
            BK_DIV:   if (r_step == QSTEP_W'(QUO_W - 1)) n_state = BK_OUT;
            BK_OUT:   if (!r_ov) n_state = run_last ? BK_IDLE : BK_SCAN;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_run_take = 1'b0;
        o_rd_en    = 1'b0;
        out_wr     = 1'b0;
        unique case (r_state)
            BK_IDLE: o_run_take = i_run_valid;
            BK_SCAN: o_rd_en    = tap_ok;
            BK_OUT:  out_wr     = !r_ov;
            default: ;
        endcase
    end

    assign o_busy    = (r_state != BK_IDLE);
    assign o_rd_slot = r_slot;
    assign o_rd_col  = CW'(cx - (CW + 1)'(HALF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= o_rd_en;
            if (out_wr) begin
                r_ov <= 1'b1;
            end else if (i_pop && r_ov) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_run_take) begin
            r_r     <= i_run_r;
            r_c     <= i_run_lo;
            r_hi    <= i_run_hi;
            r_fend  <= i_run_fend;
            r_slot0 <= take_slot;
            r_slot  <= take_slot;
            r_dy    <= '0;
            r_dx    <= '0;
            r_sb    <= '0;
            r_sg    <= '0;
            r_sr    <= '0;
            r_cnt   <= '0;
        end else if (out_wr && !run_last) begin
            r_c    <= r_c + CW'(1);
            r_slot <= r_slot0;
            r_dy   <= '0;
            r_dx   <= '0;
            r_sb   <= '0;
            r_sg   <= '0;
            r_sr   <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_state == BK_SCAN) begin
                if (r_dx == DW'(WINDOW - 1)) begin
                    r_dx   <= '0;
                    r_dy   <= r_dy + DW'(1);
                    r_slot <= (r_slot == SLW'(WINDOW - 1)) ? '0 : r_slot + SLW'(1);
                end else begin
                    r_dx <= r_dx + DW'(1);
                end
            end
            if (r_pv) begin
                r_sb  <= r_sb + SW'(i_rd_data[PIX_W-1:0]);
                r_sg  <= r_sg + SW'(i_rd_data[2*PIX_W-1:PIX_W]);
                r_sr  <= r_sr + SW'(i_rd_data[3*PIX_W-1:2*PIX_W]);
                r_cnt <= r_cnt + NW'(1);
            end
        end
    end

    // Restoring division, one quotient bit per cycle for all three channels.
    always_ff @(posedge i_clk) begin
        if (r_state == BK_LOAD) begin
            r_rb   <= XW'(r_sb);
            r_rg   <= XW'(r_sg);
            r_rr   <= XW'(r_sr);
            r_dvs  <= XW'((r_cnt == '0) ? NW'(1) : r_cnt) << (QUO_W - 1);
            r_step <= '0;
        end else if (r_state == BK_DIV) begin
            r_step <= r_step + QSTEP_W'(1);
            r_dvs  <= r_dvs >> 1;
            if (r_rb >= r_dvs) begin
                r_rb <= r_rb - r_dvs;
                r_qb <= {r_qb[QUO_W-2:0], 1'b1};
            end else begin
                r_qb <= {r_qb[QUO_W-2:0], 1'b0};
            end
            if (r_rg >= r_dvs) begin
                r_rg <= r_rg - r_dvs;
                r_qg <= {r_qg[QUO_W-2:0], 1'b1};
            end else begin
                r_qg <= {r_qg[QUO_W-2:0], 1'b0};
            end
            if (r_rr >= r_dvs) begin
                r_rr <= r_rr - r_dvs;
                r_qr <= {r_qr[QUO_W-2:0], 1'b1};
            end else begin
                r_qr <= {r_qr[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            o_avg_blue  <= r_qb;
            o_avg_green <= r_qg;
            o_avg_red   <= r_qr;
            o_run_end   <= run_last;
            o_frame_end <= r_fend && run_last;
        end
    end

    assign o_empty = !r_ov;

    `BBWM_ASSERT_IMPL(a_center_counted, i_clk, i_rst_n, r_state == BK_LOAD, r_cnt != '0)
    `BBWM_ASSERT_NEXT(a_out_written, i_clk, i_rst_n, out_wr, r_ov)
    `BBWM_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, (r_state == BK_DIV) && (r_step == QSTEP_W'(QUO_W - 1)), r_state == BK_OUT)
endmodule

>>> hw/rtl/box_blur_window_mean.sv
`timescale 1ns / 1ps
// Streaming WINDOW x WINDOW box blur over raster blue/green/red pixels. Each result channel
// is the truncated mean of the window neighbours that lie inside the image. Feed the frame
// in raster order, then WINDOW/2 rows of drain beats; results come out in raster order
// with run_end on the last result of each input beat and frame_end on the final pixel.
// Each result is computed by one shared back end that reads the line store once per window
// tap inside the image, then divides the sums; a beat at the end of a row causes up to
// WINDOW/2 + 1 results in turn. A finished result that still waits in the output
// register stalls the back end until it is popped. The front takes the next beat only
// when the back end holds no pending work, while a finished result may still wait on
// the output.
// Configuration writes take effect at once and restart the frame.
module box_blur_window_mean
    import bbwm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_op,
    input  logic [PIX_W-1:0]     i_pix_blue,
    input  logic [PIX_W-1:0]     i_pix_green,
    input  logic [PIX_W-1:0]     i_pix_red,
    output logic                 empty,
    input  logic                 pop,
    output logic [PIX_W-1:0]     o_avg_blue,
    output logic [PIX_W-1:0]     o_avg_green,
    output logic [PIX_W-1:0]     o_avg_red,
    output logic                 o_run_end,
    output logic                 o_frame_end,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SLW   = $clog2(WINDOW);
    localparam int RUN_W = ROW_W + SLW + 2 * CW + 1;

    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [WW-1:0]    eff_w;
    logic [CFG_W-1:0] eff_h;
    logic             cfg_wr;
    logic             accept;

    logic             we, rd_en;
    logic [SLW-1:0]   wr_slot, rd_slot;
    logic [CW-1:0]    wr_col, rd_col;
    logic [3*PIX_W-1:0] wr_data, rd_data;

    logic             run_push, run_valid, run_take, back_busy;
    logic [ROW_W-1:0] f_r, b_r;
    logic [SLW-1:0]   f_slot, b_slot;
    logic [CW-1:0]    f_lo, f_hi, b_lo, b_hi;
    logic             f_fend, b_fend;

    // The configuration channel is always ready; an index past the register list is dropped.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready
                      && ((i_cfg_index == CFG_IDX_WIDTH) || (i_cfg_index == CFG_IDX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_WIDTH_RESET;
            r_cfg_h <= CFG_HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_IDX_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    // The width is clamped to the line store size and a zero width or height counts as one.
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
    end
    assign eff_h = (r_cfg_h == '0) ? CFG_W'(1) : r_cfg_h;

    // A new beat is held off while any earlier run is queued or in the back end.
    assign full   = run_valid || back_busy;
    assign accept = push && !full;

    bbwm_front #(.MAX_WIDTH(MAX_WIDTH), .WINDOW(WINDOW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_op),
        .i_pix      ({i_pix_red, i_pix_green, i_pix_blue}),
        .i_w        (eff_w),
        .i_h        (eff_h),
        .i_pos_clear(cfg_wr),
        .o_we       (we),
        .o_wr_slot  (wr_slot),
        .o_wr_col   (wr_col),
        .o_wr_data  (wr_data),
        .o_run_push (run_push),
        .o_run_r    (f_r),
        .o_run_slot (f_slot),
        .o_run_lo   (f_lo),
        .o_run_hi   (f_hi),
        .o_run_fend (f_fend)
    );

    bbwm_run_fifo #(.WIDTH(RUN_W)) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (run_push),
        .i_data ({f_r, f_slot, f_lo, f_hi, f_fend}),
        .i_pop  (run_take),
        .o_valid(run_valid),
        .o_data ({b_r, b_slot, b_lo, b_hi, b_fend})
    );

    bbwm_line_mem #(.MAX_WIDTH(MAX_WIDTH), .WINDOW(WINDOW)) u_mem (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_wr_slot(wr_slot),
        .i_wr_col (wr_col),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_slot(rd_slot),
        .i_rd_col (rd_col),
        .o_rd_data(rd_data)
    );

    bbwm_back #(.MAX_WIDTH(MAX_WIDTH), .WINDOW(WINDOW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_w        (eff_w),
        .i_h        (eff_h),
        .i_run_valid(run_valid),
        .i_run_r    (b_r),
        .i_run_slot (b_slot),
        .i_run_lo   (b_lo),
        .i_run_hi   (b_hi),
        .i_run_fend (b_fend),
        .o_run_take (run_take),
        .o_busy     (back_busy),
        .o_rd_en    (rd_en),
        .o_rd_slot  (rd_slot),
        .o_rd_col   (rd_col),
        .i_rd_data  (rd_data),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_avg_blue (o_avg_blue),
        .o_avg_green(o_avg_green),
        .o_avg_red  (o_avg_red),
        .o_run_end  (o_run_end),
        .o_frame_end(o_frame_end)
    );
endmodule
